[rtl/amd_pkg.sv]
`default_nettype none
package amd_pkg;

   // one input item: one matrix column
   typedef struct packed {
      logic [1:0]          column_index;
      logic signed [31:0]  elem_x;
      logic signed [31:0]  elem_y;
      logic signed [31:0]  elem_z;
      logic signed [31:0]  elem_w;
      logic                last_column;
   } req_type;

   // one result item
   typedef struct packed {
      logic                ok;
      logic signed [31:0]  translate_x;
      logic signed [31:0]  translate_y;
      logic signed [31:0]  translate_z;
      logic signed [31:0]  rotate_x;
      logic signed [31:0]  rotate_y;
      logic signed [31:0]  rotate_z;
      logic signed [31:0]  scale_x;
      logic signed [31:0]  scale_y;
      logic signed [31:0]  scale_z;
   } rsp_type;

   typedef struct packed {
      logic idle;
      logic done;
   } core_status_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_FETCH,
      SQ_EXEC,
      SQ_WAIT,
      SQ_DONE
   } seq_state_type;

   typedef enum logic [4:0] {
      OP_CLR,    // clear result staging
      OP_CHKW,   // w near zero -> tgt
      OP_DIVM,   // dst = store[a] / w
      OP_MCLR,   // acc = 0
      OP_MAC,    // acc +/-= a*b
      OP_MOUT,   // dst = sat(floor(acc))
      OP_SQRT,   // dst = sat(isqrt(acc))
      OP_NRM,    // dst = a / b, skipped when b is zero
      OP_CHKZ,   // a near zero -> tgt
      OP_BRNN,   // a >= 0 -> tgt
      OP_BRNZ,   // a != 0 -> tgt
      OP_JMP,
      OP_NEG,    // dst = -a, saturating
      OP_CLMP,   // dst = clamp(a, -1, 1)
      OP_ATAN,   // dst = atan2(+/-a, b)
      OP_EMIT,   // result field dst = a
      OP_OK,
      OP_DONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        neg;
      logic [4:0]  dst;
      logic [4:0]  a;
      logic [4:0]  b;
      logic [7:0]  tgt;
   } uop_type;

   localparam int PROG_DEPTH = 256;
   typedef uop_type [PROG_DEPTH-1:0] prog_type;

   // working register file: m(c,r) at c*3+r for columns 0..3
   localparam logic [4:0] R_PX0  = 5'd12;
   localparam logic [4:0] R_SC0  = 5'd15;
   localparam logic [4:0] R_SK   = 5'd18;
   localparam logic [4:0] R_S    = 5'd19;
   localparam logic [4:0] R_C    = 5'd20;
   localparam logic [4:0] R_RX   = 5'd21;
   localparam logic [4:0] R_RY   = 5'd22;
   localparam logic [4:0] R_RZ   = 5'd23;
   localparam logic [4:0] R_DET  = 5'd24;
   localparam logic [4:0] R_ONE  = 5'd26;
   localparam logic [4:0] R_ZERO = 5'd27;

   // result field codes for OP_EMIT
   localparam logic [4:0] FLD_TX = 5'd0;
   localparam logic [4:0] FLD_TY = 5'd1;
   localparam logic [4:0] FLD_TZ = 5'd2;
   localparam logic [4:0] FLD_RX = 5'd3;
   localparam logic [4:0] FLD_RY = 5'd4;
   localparam logic [4:0] FLD_RZ = 5'd5;
   localparam logic [4:0] FLD_SX = 5'd6;
   localparam logic [4:0] FLD_SY = 5'd7;
   localparam logic [4:0] FLD_SZ = 5'd8;

   localparam int CORDIC_STEPS = 31;
   localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;

   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

   function automatic logic [4:0] m_addr(input int c, input int r);
      return 5'(c * 3 + r);
   endfunction

   function automatic uop_type mk(input op_type op, input logic neg, input logic [4:0] dst,
                                  input logic [4:0] a, input logic [4:0] b);
      uop_type u;
      u.op  = op;
      u.neg = neg;
      u.dst = dst;
      u.a   = a;
      u.b   = b;
      u.tgt = 8'd0;
      return u;
   endfunction

   // microprogram for one decomposition
   function automatic prog_type build_prog();
      prog_type p;
      int n;
      int jw, jz, js, jn, jc;
      int i, r, j, k, c, d, s;
      for (n = 0; n < PROG_DEPTH; n++) p[n] = mk(OP_DONE, 1'b0, 5'd0, 5'd0, 5'd0);
      n = 0;
      p[n] = mk(OP_CLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
      jw = n; p[n] = mk(OP_CHKW, 1'b0, 5'd0, 5'd0, 5'd0); n++;
      for (i = 0; i < 4; i++)
         for (r = 0; r < 3; r++) begin
            p[n] = mk(OP_DIVM, 1'b0, m_addr(i, r), 5'(i * 4 + r), 5'd0); n++;
         end
      // px = m1 x m2, det = m0 . px
      for (i = 0; i < 3; i++) begin
         j = (i + 1) % 3; k = (i + 2) % 3;
         p[n] = mk(OP_MCLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
         p[n] = mk(OP_MAC, 1'b0, 5'd0, m_addr(1, j), m_addr(2, k)); n++;
         p[n] = mk(OP_MAC, 1'b1, 5'd0, m_addr(1, k), m_addr(2, j)); n++;
         p[n] = mk(OP_MOUT, 1'b0, R_PX0 + 5'(i), 5'd0, 5'd0); n++;
      end
      p[n] = mk(OP_MCLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
      for (r = 0; r < 3; r++) begin
         p[n] = mk(OP_MAC, 1'b0, 5'd0, m_addr(0, r), R_PX0 + 5'(r)); n++;
      end
      p[n] = mk(OP_MOUT, 1'b0, R_DET, 5'd0, 5'd0); n++;
      jz = n; p[n] = mk(OP_CHKZ, 1'b0, 5'd0, R_DET, 5'd0); n++;
      // Gram-Schmidt: column c gets its length, then later columns lose c's share
      for (c = 0; c < 3; c++) begin
         if (c > 0) begin
            for (s = 0; s < c; s++) begin
               p[n] = mk(OP_MCLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
               for (r = 0; r < 3; r++) begin
                  p[n] = mk(OP_MAC, 1'b0, 5'd0, m_addr(s, r), m_addr(c, r)); n++;
               end
               p[n] = mk(OP_MOUT, 1'b0, R_SK, 5'd0, 5'd0); n++;
               d = c;
               for (r = 0; r < 3; r++) begin
                  p[n] = mk(OP_MCLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
                  p[n] = mk(OP_MAC, 1'b0, 5'd0, m_addr(d, r), R_ONE); n++;
                  p[n] = mk(OP_MAC, 1'b1, 5'd0, m_addr(s, r), R_SK); n++;
                  p[n] = mk(OP_MOUT, 1'b0, m_addr(d, r), 5'd0, 5'd0); n++;
               end
            end
         end
         p[n] = mk(OP_MCLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
         for (r = 0; r < 3; r++) begin
            p[n] = mk(OP_MAC, 1'b0, 5'd0, m_addr(c, r), m_addr(c, r)); n++;
         end
         p[n] = mk(OP_SQRT, 1'b0, R_SC0 + 5'(c), 5'd0, 5'd0); n++;
         for (r = 0; r < 3; r++) begin
            p[n] = mk(OP_NRM, 1'b0, m_addr(c, r), m_addr(c, r), R_SC0 + 5'(c)); n++;
         end
      end
      // handedness of the orthonormal basis
      for (i = 0; i < 3; i++) begin
         j = (i + 1) % 3; k = (i + 2) % 3;
         p[n] = mk(OP_MCLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
         p[n] = mk(OP_MAC, 1'b0, 5'd0, m_addr(1, j), m_addr(2, k)); n++;
         p[n] = mk(OP_MAC, 1'b1, 5'd0, m_addr(1, k), m_addr(2, j)); n++;
         p[n] = mk(OP_MOUT, 1'b0, R_PX0 + 5'(i), 5'd0, 5'd0); n++;
      end
      p[n] = mk(OP_MCLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
      for (r = 0; r < 3; r++) begin
         p[n] = mk(OP_MAC, 1'b0, 5'd0, m_addr(0, r), R_PX0 + 5'(r)); n++;
      end
      p[n] = mk(OP_MOUT, 1'b0, R_DET, 5'd0, 5'd0); n++;
      js = n; p[n] = mk(OP_BRNN, 1'b0, 5'd0, R_DET, 5'd0); n++;
      for (i = 0; i < 3; i++) begin
         p[n] = mk(OP_NEG, 1'b0, R_SC0 + 5'(i), R_SC0 + 5'(i), 5'd0); n++;
      end
      for (i = 0; i < 3; i++)
         for (r = 0; r < 3; r++) begin
            p[n] = mk(OP_NEG, 1'b0, m_addr(i, r), m_addr(i, r), 5'd0); n++;
         end
      p[js].tgt = 8'(n);
      // angles
      p[n] = mk(OP_NEG, 1'b0, R_S, m_addr(0, 2), 5'd0); n++;
      p[n] = mk(OP_CLMP, 1'b0, R_S, R_S, 5'd0); n++;
      p[n] = mk(OP_MCLR, 1'b0, 5'd0, 5'd0, 5'd0); n++;
      p[n] = mk(OP_MAC, 1'b0, 5'd0, R_ONE, R_ONE); n++;
      p[n] = mk(OP_MAC, 1'b1, 5'd0, R_S, R_S); n++;
      p[n] = mk(OP_SQRT, 1'b0, R_C, 5'd0, 5'd0); n++;
      p[n] = mk(OP_ATAN, 1'b0, R_RY, R_S, R_C); n++;
      jn = n; p[n] = mk(OP_BRNZ, 1'b0, 5'd0, R_C, 5'd0); n++;
      p[n] = mk(OP_ATAN, 1'b1, R_RX, m_addr(2, 0), m_addr(1, 1)); n++;
      jc = n; p[n] = mk(OP_JMP, 1'b0, 5'd0, 5'd0, 5'd0); n++;
      p[jn].tgt = 8'(n);
      p[n] = mk(OP_ATAN, 1'b0, R_RX, m_addr(1, 2), m_addr(2, 2)); n++;
      p[n] = mk(OP_ATAN, 1'b0, R_RZ, m_addr(0, 1), m_addr(0, 0)); n++;
      p[n] = mk(OP_EMIT, 1'b0, FLD_RZ, R_RZ, 5'd0); n++;
      p[jc].tgt = 8'(n);
      p[n] = mk(OP_EMIT, 1'b0, FLD_TX, m_addr(3, 0), 5'd0); n++;
      p[n] = mk(OP_EMIT, 1'b0, FLD_TY, m_addr(3, 1), 5'd0); n++;
      p[n] = mk(OP_EMIT, 1'b0, FLD_TZ, m_addr(3, 2), 5'd0); n++;
      p[n] = mk(OP_EMIT, 1'b0, FLD_RX, R_RX, 5'd0); n++;
      p[n] = mk(OP_EMIT, 1'b0, FLD_RY, R_RY, 5'd0); n++;
      p[n] = mk(OP_EMIT, 1'b0, FLD_SX, R_SC0, 5'd0); n++;
      p[n] = mk(OP_EMIT, 1'b0, FLD_SY, R_SC0 + 5'd1, 5'd0); n++;
      p[n] = mk(OP_EMIT, 1'b0, FLD_SZ, R_SC0 + 5'd2, 5'd0); n++;
      p[n] = mk(OP_OK, 1'b0, 5'd0, 5'd0, 5'd0); n++;
      p[n] = mk(OP_DONE, 1'b0, 5'd0, 5'd0, 5'd0); n++;
      // failure: staging already cleared
      p[jw].tgt = 8'(n);
      p[jz].tgt = 8'(n);
      p[n] = mk(OP_DONE, 1'b0, 5'd0, 5'd0, 5'd0);
      return p;
   endfunction

endpackage
`default_nettype wire

[rtl/amd_mac.sv]
`default_nettype none
module amd_mac (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clr,
   input  wire logic                mul_en,
   input  wire logic                neg,
   input  wire logic signed [31:0]  op_a,
   input  wire logic signed [31:0]  op_b,
   output logic signed [65:0]       acc
);

   logic signed [63:0] prod_ff;
   logic               pend_ff, pend_in;
   logic               neg_ff;
   logic signed [65:0] acc_ff, acc_in;

   // product registered, accumulated in the following cycle
   always_comb begin
      pend_in = mul_en;
      acc_in  = acc_ff;
      if (clr) begin
         acc_in = '0;
      end else if (pend_ff) begin
         if (neg_ff) begin
            acc_in = acc_ff - 66'(prod_ff);
         end else begin
            acc_in = acc_ff + 66'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      prod_ff <= op_a * op_b;
      neg_ff  <= neg;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

[rtl/amd_divsqrt.sv]
`default_nettype none
module amd_divsqrt #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                is_sqrt,
   input  wire logic signed [31:0]  div_a,
   input  wire logic signed [31:0]  div_d,
   input  wire logic [65:0]         rad,
   output logic                     done,
   output logic signed [31:0]       result
);

   localparam int DW = 32 + FRAC_BITS;
   localparam int CW = $clog2(DW + 1);
   localparam logic [DW-1:0] QMAX = DW'(32'h7FFF_FFFF);
   localparam logic [DW-1:0] QMIN = DW'(33'h0_8000_0000);

   logic [DW-1:0]       q_ff, q_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         dmag_ff, dmag_in;
   logic                neg_ff, neg_in;
   logic                sqrt_ff, sqrt_in;
   logic [65:0]         rad_ff, rad_in;
   logic [32:0]         root_ff, root_in;
   logic [34:0]         srem_ff, srem_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic signed [31:0]  res_ff, res_in;

   logic [32:0] rsh;
   logic        dge;
   logic [36:0] ssh, trial;
   logic        sge;
   logic [31:0] amag;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      sqrt_in = sqrt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      srem_in = srem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      amag    = div_a[31] ? 32'(-div_a) : 32'(div_a);
      rsh     = {rem_ff, q_ff[DW-1]};
      dge     = rsh >= {1'b0, dmag_ff};
      ssh     = {srem_ff, rad_ff[65:64]};
      trial   = {2'b00, root_ff, 2'b01};
      sge     = ssh >= trial;
      if (start) begin
         busy_in = 1'b1;
         sqrt_in = is_sqrt;
         rad_in  = rad;
         root_in = '0;
         srem_in = '0;
         q_in    = DW'(amag) << FRAC_BITS;
         rem_in  = '0;
         dmag_in = div_d[31] ? 32'(-div_d) : 32'(div_d);
         neg_in  = div_a[31] ^ div_d[31];
         cnt_in  = is_sqrt ? CW'(33) : CW'(DW);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (sqrt_ff) begin
            rad_in = {rad_ff[63:0], 2'b00};
            if (sge) begin
               srem_in = 35'(ssh - trial);
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               srem_in = ssh[34:0];
               root_in = {root_ff[31:0], 1'b0};
            end
         end else begin
            rem_in = dge ? 32'(rsh - {1'b0, dmag_ff}) : rsh[31:0];
            q_in   = {q_ff[DW-2:0], dge};
         end
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (sqrt_ff) begin
               res_in = (root_in > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(root_in);
            end else if (!neg_ff) begin
               res_in = (q_in > QMAX) ? 32'sh7FFF_FFFF : 32'(q_in);
            end else begin
               res_in = (q_in > QMIN) ? 32'sh8000_0000 : -(32'(q_in));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
      sqrt_ff <= sqrt_in;
      rad_ff  <= rad_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

[rtl/amd_cordic.sv]
`default_nettype none
module amd_cordic #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic signed [32:0]  y_in,
   input  wire logic signed [31:0]  x_in,
   output logic                     done,
   output logic signed [31:0]       result
);

   localparam logic signed [35:0] LIM  = 36'sd1 <<< 30;
   localparam logic signed [35:0] RND  = 36'sd1 <<< (29 - FRAC_BITS);
   localparam logic [4:0]         LAST = 5'(amd_pkg::CORDIC_STEPS - 1);

   logic signed [35:0] x_ff, x_in_n, y_ff, y_in_n, z_ff, z_in;
   logic [4:0]         i_ff, i_in;
   logic               norm_ff, norm_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [31:0] res_ff, res_in;

   logic signed [35:0] x0, y0, dx, dy, ymag, zr, zs, ang;

   function automatic logic signed [32:0] atan_q30_s(input logic [4:0] idx);
      return 33'(amd_pkg::atan_q30(idx));
   endfunction

   always_comb begin
      x_in_n  = x_ff;
      y_in_n  = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      norm_in = norm_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      x0      = 36'(x_in);
      y0      = 36'(y_in);
      ymag    = y_ff[35] ? -y_ff : y_ff;
      dx      = x_ff >>> i_ff;
      dy      = y_ff >>> i_ff;
      ang     = 36'(atan_q30_s(i_ff));
      zr      = '0;
      zs      = '0;
      if (start) begin
         if (x_in == 32'sd0 && y_in == 33'sd0) begin
            done_in = 1'b1;
            res_in  = '0;
         end else begin
            busy_in = 1'b1;
            norm_in = 1'b1;
            i_in    = '0;
            if (x_in < 0) begin
               z_in   = (y_in >= 0) ? amd_pkg::PI_Q30 : -amd_pkg::PI_Q30;
               x_in_n = -x0;
               y_in_n = -y0;
            end else begin
               z_in   = '0;
               x_in_n = x0;
               y_in_n = y0;
            end
         end
      end else if (busy_ff && norm_ff) begin
         // scale up until one magnitude reaches 2^30
         if (x_ff < LIM && ymag < LIM) begin
            x_in_n = x_ff <<< 1;
            y_in_n = y_ff <<< 1;
         end else begin
            norm_in = 1'b0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in_n = x_ff + dy;
            y_in_n = y_ff - dx;
            z_in   = z_ff + ang;
         end else begin
            x_in_n = x_ff - dy;
            y_in_n = y_ff + dx;
            z_in   = z_ff - ang;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            zr      = z_in + RND;
            zs      = zr >>> (30 - FRAC_BITS);
            if (zs > 36'sh0_7FFF_FFFF) begin
               res_in = 32'sh7FFF_FFFF;
            end else if (zs < -36'sh0_8000_0000) begin
               res_in = 32'sh8000_0000;
            end else begin
               res_in = 32'(zs);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in_n;
      y_ff    <= y_in_n;
      z_ff    <= z_in;
      i_ff    <= i_in;
      norm_ff <= norm_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

[rtl/amd_core.sv]
`default_nettype none
module amd_core #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_accept,
   input  wire amd_pkg::req_type        req_item,
   input  wire logic [15:0]             threshold,
   input  wire logic                    out_free,
   output amd_pkg::core_status_type     status,
   output amd_pkg::rsp_type             result
);

   localparam amd_pkg::prog_type PROG = amd_pkg::build_prog();
   localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] SMIN = 32'sh8000_0000;

   amd_pkg::seq_state_type state_ff, state_in;
   logic [7:0]             pc_ff, pc_in;
   amd_pkg::rsp_type       stage_ff, stage_in;
   amd_pkg::uop_type       cur;

   logic signed [31:0] store_ff [16];
   logic signed [31:0] ram [32];
   logic signed [31:0] ra_q, rb_q, opa, opb;

   logic               exec, we;
   logic signed [31:0] wdata;
   logic signed [65:0] acc, acc_sh;
   logic signed [31:0] mac_out;
   logic               ds_start, ds_done, co_start, co_done, unit_done;
   logic signed [31:0] ds_a, ds_d, ds_res, co_res, unit_res;
   logic signed [32:0] co_y;
   logic signed [31:0] w_val;

   function automatic logic near_zero(input logic signed [31:0] v, input logic [15:0] t);
      logic signed [32:0] ve;
      logic [32:0]        mag;
      ve  = 33'(v);
      mag = ve[32] ? 33'(-ve) : 33'(ve);
      return (v == 32'sd0) || (mag < 33'(t));
   endfunction

   assign cur   = PROG[pc_ff];
   assign exec  = (state_ff == amd_pkg::SQ_EXEC);
   assign w_val = store_ff[15];
   assign opa   = (cur.a == amd_pkg::R_ONE) ? ONE : (cur.a == amd_pkg::R_ZERO) ? 32'sd0 : ra_q;
   assign opb   = (cur.b == amd_pkg::R_ONE) ? ONE : (cur.b == amd_pkg::R_ZERO) ? 32'sd0 : rb_q;

   // floor(acc / 2^F), saturated
   assign acc_sh  = acc >>> FRAC_BITS;
   assign mac_out = (acc_sh > 66'(SMAX)) ? SMAX : (acc_sh < 66'(SMIN)) ? SMIN : 32'(acc_sh);

   assign ds_start = exec && ((cur.op == amd_pkg::OP_DIVM) || (cur.op == amd_pkg::OP_SQRT)
                     || ((cur.op == amd_pkg::OP_NRM) && (opb != 32'sd0)));
   assign ds_a     = (cur.op == amd_pkg::OP_DIVM) ? store_ff[cur.a[3:0]] : opa;
   assign ds_d     = (cur.op == amd_pkg::OP_DIVM) ? w_val : opb;
   assign co_start = exec && (cur.op == amd_pkg::OP_ATAN);
   assign co_y     = cur.neg ? -(33'(opa)) : 33'(opa);
   assign unit_done = ds_done | co_done;
   assign unit_res  = ds_done ? ds_res : co_res;

   amd_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .clr    (exec && (cur.op == amd_pkg::OP_MCLR)),
      .mul_en (exec && (cur.op == amd_pkg::OP_MAC)),
      .neg    (cur.neg),
      .op_a   (opa),
      .op_b   (opb),
      .acc    (acc)
   );

   amd_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_divsqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (ds_start),
      .is_sqrt (cur.op == amd_pkg::OP_SQRT),
      .div_a   (ds_a),
      .div_d   (ds_d),
      .rad     (acc),
      .done    (ds_done),
      .result  (ds_res)
   );

   amd_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (co_start),
      .y_in   (co_y),
      .x_in   (opb),
      .done   (co_done),
      .result (co_res)
   );

   // next state and program counter
   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (state_ff)
         amd_pkg::SQ_IDLE: begin
            if (req_accept && req_item.last_column) begin
               state_in = amd_pkg::SQ_FETCH;
               pc_in    = 8'd0;
            end
         end
         amd_pkg::SQ_FETCH: state_in = amd_pkg::SQ_EXEC;
         amd_pkg::SQ_EXEC: begin
            state_in = amd_pkg::SQ_FETCH;
            pc_in    = pc_ff + 8'd1;
            case (cur.op)
               amd_pkg::OP_CHKW: if (near_zero(w_val, threshold)) pc_in = cur.tgt;
               amd_pkg::OP_CHKZ: if (near_zero(opa, threshold)) pc_in = cur.tgt;
               amd_pkg::OP_BRNN: if (opa >= 0) pc_in = cur.tgt;
               amd_pkg::OP_BRNZ: if (opa != 32'sd0) pc_in = cur.tgt;
               amd_pkg::OP_JMP:  pc_in = cur.tgt;
               amd_pkg::OP_DIVM, amd_pkg::OP_SQRT, amd_pkg::OP_ATAN: begin
                  state_in = amd_pkg::SQ_WAIT;
                  pc_in    = pc_ff;
               end
               amd_pkg::OP_NRM: begin
                  if (opb != 32'sd0) begin
                     state_in = amd_pkg::SQ_WAIT;
                     pc_in    = pc_ff;
                  end
               end
               amd_pkg::OP_DONE: begin
                  state_in = amd_pkg::SQ_DONE;
                  pc_in    = pc_ff;
               end
               default: ;
            endcase
         end
         amd_pkg::SQ_WAIT: begin
            if (unit_done) begin
               state_in = amd_pkg::SQ_FETCH;
               pc_in    = pc_ff + 8'd1;
            end
         end
         amd_pkg::SQ_DONE: if (out_free) state_in = amd_pkg::SQ_IDLE;
         default: state_in = amd_pkg::SQ_IDLE;
      endcase
   end

   // register file writes and result staging
   always_comb begin
      we       = 1'b0;
      wdata    = mac_out;
      stage_in = stage_ff;
      if (exec) begin
         case (cur.op)
            amd_pkg::OP_MOUT: we = 1'b1;
            amd_pkg::OP_NEG: begin
               we    = 1'b1;
               wdata = (opa == SMIN) ? SMAX : -opa;
            end
            amd_pkg::OP_CLMP: begin
               we    = 1'b1;
               wdata = (opa > ONE) ? ONE : (opa < -ONE) ? -ONE : opa;
            end
            amd_pkg::OP_CLR: stage_in = '0;
            amd_pkg::OP_OK:  stage_in.ok = 1'b1;
            amd_pkg::OP_EMIT: begin
               case (cur.dst)
                  amd_pkg::FLD_TX: stage_in.translate_x = opa;
                  amd_pkg::FLD_TY: stage_in.translate_y = opa;
                  amd_pkg::FLD_TZ: stage_in.translate_z = opa;
                  amd_pkg::FLD_RX: stage_in.rotate_x    = opa;
                  amd_pkg::FLD_RY: stage_in.rotate_y    = opa;
                  amd_pkg::FLD_RZ: stage_in.rotate_z    = opa;
                  amd_pkg::FLD_SX: stage_in.scale_x     = opa;
                  amd_pkg::FLD_SY: stage_in.scale_y     = opa;
                  amd_pkg::FLD_SZ: stage_in.scale_z     = opa;
                  default: ;
               endcase
            end
            default: ;
         endcase
      end else if ((state_ff == amd_pkg::SQ_WAIT) && unit_done) begin
         we    = 1'b1;
         wdata = unit_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amd_pkg::SQ_IDLE;
         pc_ff    <= 8'd0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
      stage_ff <= stage_in;
   end

   // column store
   always_ff @(posedge clock) begin
      for (int c = 0; c < 4; c++) begin
         if (req_accept && (req_item.column_index == 2'(c))) begin
            store_ff[c*4+0] <= req_item.elem_x;
            store_ff[c*4+1] <= req_item.elem_y;
            store_ff[c*4+2] <= req_item.elem_z;
            store_ff[c*4+3] <= req_item.elem_w;
         end
      end
   end

   // working registers: one write, two registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         ram[cur.dst] <= wdata;
      end
      ra_q <= ram[cur.a];
      rb_q <= ram[cur.b];
   end

   assign status.idle = (state_ff == amd_pkg::SQ_IDLE);
   assign status.done = (state_ff == amd_pkg::SQ_DONE) && out_free;
   assign result      = stage_ff;

endmodule
`default_nettype wire

[rtl/affine_matrix_decompose.sv]
// Affine 4x4 transform decomposition: translation, Euler angles, scales.
//
// req channel: one item per matrix column, signed Q16.16 (FRAC_BITS). Items
//   without last_column are stored and give no result. The item
//   with last_column starts the decomposition of the stored matrix.
// rsp channel: one item per last_column item. ok=0 (zero w or singular
//   basis) comes with every other field zero.
// csr channel: near-zero threshold, always ready; write it only while idle.
// Sequencing: a decomposition runs a microprogram of about 160 steps on one
//   multiply-accumulate unit, one radix-2 divide/square-root unit and one
//   CORDIC unit. Each step passes through a fetch and an execute state; the
//   21 divisions, the square roots and the atan2 steps then wait for their
//   unit to finish. req_ready is low until the sequencer is idle again.
// The result sits in an output register; a stalled receiver holds it and a
//   following decomposition waits at its end until the register is free.
// Reset: sequencer idle, no result pending, threshold 1. The column store
//   is not cleared; all four columns must be sent before a last_column item.
`default_nettype none
module affine_matrix_decompose #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire amd_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output amd_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [15:0]       csr_data
);

   logic [15:0]                 thr_ff, thr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   amd_pkg::rsp_type            rsp_ff, rsp_in;
   amd_pkg::core_status_type    core_status;
   amd_pkg::rsp_type            core_result;
   logic                        out_free;
   logic                        req_accept;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign req_ready  = core_status.idle;
   assign csr_ready  = 1'b1;

   amd_core #(.FRAC_BITS(FRAC_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_item   (req_data),
      .threshold  (thr_ff),
      .out_free   (out_free),
      .status     (core_status),
      .result     (core_result)
   );

   // threshold and output register
   always_comb begin
      thr_in       = csr_valid ? csr_data : thr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (core_status.done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = core_result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= 16'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a finished result never overwrites one still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      core_status.done |-> out_free)
      else $error("result overwritten while pending");

   // a failed decomposition carries all-zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.ok) |-> (rsp_ff.translate_x == 0 && rsp_ff.translate_y == 0 &&
         rsp_ff.translate_z == 0 && rsp_ff.rotate_x == 0 && rsp_ff.rotate_y == 0 &&
         rsp_ff.rotate_z == 0 && rsp_ff.scale_x == 0 && rsp_ff.scale_y == 0 &&
         rsp_ff.scale_z == 0))
      else $error("failed result with non-zero field");

   // a result appears only after the sequencer finished
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(core_status.done))
      else $error("result without decomposition");
`endif

endmodule
`default_nettype wire

[tb/affine_matrix_decompose_tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module affine_matrix_decompose_tb;

   localparam longint ONE_Q = 64'sd65536;     // 1.0 in Q16.16
   localparam longint PI_Z  = 64'sd3373259426; // pi in Q30
   localparam int     SETTLE = 40;            // cycles after the last result

   // CORDIC arctangent steps, Q30
   localparam longint ATAN_STEP [0:30] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
      64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
      64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
      64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001};

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   amd_pkg::req_type  req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   amd_pkg::rsp_type  rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [15:0]       csr_data;

   affine_matrix_decompose DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // predictor state: column store mirror and threshold
   int               col_store [16];
   int unsigned      zero_thresh;
   amd_pkg::rsp_type pending_decomps [$];
   int               err_count;
   int               items_sent;

   // sender burst control
   bit          valid_up;
   int          burst_left;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // fixed-point helpers, all exact until the final floor/saturate
   // ---------------------------------------------------------------
   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   // floor(sum of three products / 2^16), saturated
   function automatic int mac3(longint a0, longint b0, longint a1, longint b1,
                               longint a2, longint b2);
      logic signed [95:0] acc;
      acc = 96'sd0;
      acc += a0 * b0;
      acc += a1 * b1;
      acc += a2 * b2;
      acc = acc >>> 16;
      if (acc > 96'sd2147483647) return 32'sh7FFFFFFF;
      if (acc < -96'sd2147483648) return 32'sh80000000;
      return int'(acc);
   endfunction

   function automatic int dot_q(int u [3], int v [3]);
      return mac3(u[0], v[0], u[1], v[1], u[2], v[2]);
   endfunction

   function automatic void cross_q(int u [3], int v [3], output int o [3]);
      int j, k;
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         o[i] = mac3(u[j], v[k], u[k], -longint'(v[j]), 0, 0);
      end
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] n);
      logic [63:0] r, b;
      r = 64'd0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic int length_q(int u [3]);
      logic [63:0] s, r;
      s = 64'd0;
      for (int i = 0; i < 3; i++) s += 64'(longint'(u[i]) * longint'(u[i]));
      r = int_sqrt(s);
      return (r > 64'd2147483647) ? 32'sh7FFFFFFF : int'(r);
   endfunction

   function automatic void normalise_q(inout int u [3], input int l);
      if (l == 0) return;
      for (int i = 0; i < 3; i++) u[i] = sat32((longint'(u[i]) * ONE_Q) / l);
   endfunction

   function automatic bit is_near_zero(longint v);
      return (v == 0) || ((v < 0 ? -v : v) < longint'(zero_thresh));
   endfunction

   // CORDIC atan2 in Q30, result rounded to Q16.16
   function automatic int atan2_q(longint y, longint x);
      longint z, dx, dy;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_Z : -PI_Z;
         x = -x;
         y = -y;
      end
      while (x < (64'sd1 <<< 30) && (y < 0 ? -y : y) < (64'sd1 <<< 30)) begin
         x = x * 2;
         y = y * 2;
      end
      for (int i = 0; i < 31; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y > 0) begin
            x += dy; y -= dx; z += ATAN_STEP[i];
         end else begin
            x -= dy; y += dx; z -= ATAN_STEP[i];
         end
      end
      return sat32((z + (64'sd1 <<< 13)) >>> 14);
   endfunction

   // full decomposition of the mirrored store
   function automatic amd_pkg::rsp_type decompose_store();
      amd_pkg::rsp_type o;
      int m [4][3];
      int px [3];
      int tmp [3];
      int sc [3];
      int sk, s, c;
      longint w;
      o = '0;
      w = col_store[15];
      if (is_near_zero(w)) return o;
      for (int i = 0; i < 4; i++)
         for (int r = 0; r < 3; r++)
            m[i][r] = sat32((longint'(col_store[i*4+r]) * ONE_Q) / w);
      cross_q(m[1], m[2], px);
      if (is_near_zero(dot_q(m[0], px))) return o;
      o.ok = 1'b1;
      o.translate_x = m[3][0];
      o.translate_y = m[3][1];
      o.translate_z = m[3][2];
      // Gram-Schmidt: same order as the block works through
      sc[0] = length_q(m[0]);
      tmp = m[0]; normalise_q(tmp, sc[0]); m[0] = tmp;
      sk = dot_q(m[0], m[1]);
      for (int r = 0; r < 3; r++) m[1][r] = mac3(m[1][r], ONE_Q, m[0][r], -longint'(sk), 0, 0);
      sc[1] = length_q(m[1]);
      tmp = m[1]; normalise_q(tmp, sc[1]); m[1] = tmp;
      sk = dot_q(m[0], m[2]);
      for (int r = 0; r < 3; r++) m[2][r] = mac3(m[2][r], ONE_Q, m[0][r], -longint'(sk), 0, 0);
      sk = dot_q(m[1], m[2]);
      for (int r = 0; r < 3; r++) m[2][r] = mac3(m[2][r], ONE_Q, m[1][r], -longint'(sk), 0, 0);
      sc[2] = length_q(m[2]);
      tmp = m[2]; normalise_q(tmp, sc[2]); m[2] = tmp;
      // left-handed basis: negate scales and columns
      cross_q(m[1], m[2], px);
      if (dot_q(m[0], px) < 0) begin
         for (int i = 0; i < 3; i++) begin
            sc[i] = sat32(-longint'(sc[i]));
            for (int r = 0; r < 3; r++) m[i][r] = sat32(-longint'(m[i][r]));
         end
      end
      o.scale_x = sc[0];
      o.scale_y = sc[1];
      o.scale_z = sc[2];
      s = sat32(-longint'(m[0][2]));
      if (s > int'(ONE_Q)) s = int'(ONE_Q);
      if (s < -int'(ONE_Q)) s = -int'(ONE_Q);
      c = int'(int_sqrt(64'(ONE_Q * ONE_Q - longint'(s) * longint'(s))));
      o.rotate_y = atan2_q(s, c);
      if (c != 0) begin
         o.rotate_x = atan2_q(m[1][2], m[2][2]);
         o.rotate_z = atan2_q(m[0][1], m[0][0]);
      end else begin
         // gimbal lock: roll folded into x, z held at zero
         o.rotate_x = atan2_q(-longint'(m[2][0]), m[1][1]);
         o.rotate_z = 0;
      end
      return o;
   endfunction

   // ---------------------------------------------------------------
   // sender: one column item, bursts with random gaps
   // ---------------------------------------------------------------
   task automatic send_column(logic [1:0] idx, int x, int y, int z, int w, bit last);
      amd_pkg::req_type it;
      int gap;
      it.column_index = idx;
      it.elem_x = x;
      it.elem_y = y;
      it.elem_z = z;
      it.elem_w = w;
      it.last_column = last;
      req_data <= it;
      if (!valid_up) begin
         req_valid <= 1'b1;
         valid_up = 1'b1;
      end
      do @(posedge clock); while (!req_ready);
      // item taken at this edge: update the mirror and predict
      col_store[idx*4+0] = x;
      col_store[idx*4+1] = y;
      col_store[idx*4+2] = z;
      col_store[idx*4+3] = w;
      items_sent++;
      if (last) pending_decomps.push_back(decompose_store());
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // long bursts now and then leave stretches with no gaps
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 25);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // sender idles until every result is home
   task automatic drain_results();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 1'b0;
      end
      while (pending_decomps.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_threshold(logic [15:0] v);
      drain_results();
      csr_data  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      zero_thresh = v;
   endtask

   // columns 0..3 in order, last flag on the translation column
   task automatic send_matrix(int c [4][4]);
      for (int i = 0; i < 4; i++)
         send_column(2'(i), c[i][0], c[i][1], c[i][2], c[i][3], i == 3);
   endtask

   function automatic int rand_elem(int kind);
      case (kind)
         0: return int'($urandom_range(0, 262143)) - 131072;   // about +/-2.0
         1: return int'($urandom_range(0, 4194303)) - 2097152; // about +/-32
         default: return int'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------
   // named tests
   // ---------------------------------------------------------------
   task automatic test_basic_shapes();
      int c [4][4];
      // identity with translation
      c = '{'{65536, 0, 0, 0}, '{0, 65536, 0, 0}, '{0, 0, 65536, 0},
            '{196608, -131072, 32768, 65536}};
      send_matrix(c);
      // non-uniform scale, w of 2.0
      c = '{'{131072, 0, 0, 0}, '{0, 196608, 0, 0}, '{0, 0, 32768, 0},
            '{65536, 65536, 65536, 131072}};
      send_matrix(c);
      // mirrored x axis: scales come out negated
      c = '{'{-65536, 0, 0, 0}, '{0, 65536, 0, 0}, '{0, 0, 65536, 0},
            '{0, 0, 0, 65536}};
      send_matrix(c);
      // a real rotation about z
      c = '{'{46341, 46341, 0, 0}, '{-46341, 46341, 0, 0}, '{0, 0, 65536, 0},
            '{0, 0, 0, 65536}};
      send_matrix(c);
   endtask

   task automatic test_failure_cases();
      // zero w on the translation column
      send_column(2'd0, 65536, 0, 0, 0, 1'b0);
      send_column(2'd1, 0, 65536, 0, 0, 1'b0);
      send_column(2'd2, 0, 0, 65536, 0, 1'b0);
      send_column(2'd3, 1000, 2000, 3000, 0, 1'b1);
      // singular basis: column 2 repeats column 0
      send_column(2'd2, 65536, 0, 0, 0, 1'b0);
      send_column(2'd3, 0, 0, 0, 65536, 1'b1);
   endtask

   task automatic test_gimbal_lock();
      // column 0 points down z: sine of pitch is one
      send_column(2'd0, 0, 0, -65536, 0, 1'b0);
      send_column(2'd1, 0, 65536, 0, 0, 1'b0);
      send_column(2'd2, 65536, 0, 0, 0, 1'b0);
      send_column(2'd3, 5, 6, 7, 65536, 1'b1);
      // and pointing up z
      send_column(2'd0, 0, 0, 65536, 0, 1'b0);
      send_column(2'd2, -65536, 0, 0, 0, 1'b1);
   endtask

   task automatic test_extremes();
      // saturating divide by the smallest w, then full-scale elements
      send_column(2'd0, 32'sh7FFFFFFF, 32'sh80000000, 1, 32'sh7FFFFFFF, 1'b0);
      send_column(2'd1, 32'sh80000000, 32'sh7FFFFFFF, -1, 32'sh80000000, 1'b0);
      send_column(2'd2, 0, 1, 32'sh7FFFFFFF, -1, 1'b0);
      send_column(2'd3, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1, 1'b1);
      send_column(2'd3, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 1'b1);
      // repeated column, last flag on a basis column
      send_column(2'd1, 0, 65536, 0, 0, 1'b0);
      send_column(2'd1, 0, -65536, 0, 0, 1'b0);
      send_column(2'd3, 0, 0, 0, 65536, 1'b0);
      send_column(2'd0, 65536, 0, 0, 0, 1'b1);
   endtask

   task automatic test_threshold_edges();
      set_threshold(16'hFFFF);
      // half w is below the largest threshold
      send_column(2'd3, 0, 0, 0, 32768, 1'b1);
      // small basis: determinant 1/8 falls under the threshold
      send_column(2'd0, 32768, 0, 0, 0, 1'b0);
      send_column(2'd1, 0, 32768, 0, 0, 1'b0);
      send_column(2'd2, 0, 0, 32768, 0, 1'b0);
      send_column(2'd3, 0, 0, 0, 65536, 1'b1);
      set_threshold(16'h0000);
      // w of one lsb is no longer zero
      send_column(2'd3, 1, 1, 1, 1, 1'b1);
      drain_results();
   endtask

   // mostly well-formed matrices with random content, some noise
   task automatic test_random_matrices(int n_items);
      int order [4];
      int kind, pick, t, target;
      int col [4];
      target = items_sent + n_items;
      while (items_sent < target) begin
         pick = $urandom_range(0, 19);
         kind = $urandom_range(0, 9) < 6 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
         if (pick == 0) drain_results();
         if (pick < 13) begin
            order = '{0, 1, 2, 3};
            for (int i = 3; i > 0; i--) begin
               t = $urandom_range(0, i);
               {order[i], order[t]} = {order[t], order[i]};
            end
            for (int i = 0; i < 4; i++) begin
               col[0] = rand_elem(kind);
               col[1] = rand_elem(kind);
               col[2] = rand_elem(kind);
               col[3] = int'($urandom());
               if (order[i] == 3) begin
                  case ($urandom_range(0, 9))
                     0:       col[3] = 0;
                     1:       col[3] = int'($urandom_range(0, 131071)) - 65536;
                     2:       col[3] = int'($urandom());
                     default: col[3] = 65536;
                  endcase
               end
               if (order[i] == 0 && $urandom_range(0, 7) == 0) begin
                  // basis column on z alone: exercises the gimbal branch
                  col[0] = 0;
                  col[1] = 0;
               end
               send_column(2'(order[i]), col[0], col[1], col[2], col[3], i == 3);
            end
         end else if (pick < 17) begin
            // partial update of an already full store
            t = $urandom_range(1, 3);
            for (int i = 0; i < t; i++)
               send_column(2'($urandom_range(0, 3)), rand_elem(kind), rand_elem(kind),
                           rand_elem(kind), ($urandom_range(0, 1) ? 65536 : int'($urandom())),
                           i == t - 1);
         end else begin
            // noise: full-range columns without a result
            send_column(2'($urandom_range(0, 3)), int'($urandom()), int'($urandom()),
                        int'($urandom()), int'($urandom()), 1'b0);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // receiver: own stall pattern, checks each result as it lands
   // ---------------------------------------------------------------
   int unsigned rx_cycle;

   task automatic check_field(string name, longint expv, longint actv);
      if (expv != actv) begin
         $error("%s: expected %0d, got %0d", name, expv, actv);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      amd_pkg::rsp_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_cycle  <= 0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         case ((rx_cycle / 3000) % 3)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ((rx_cycle % 16) >= 11);
         endcase
         if (rsp_valid && rsp_ready) begin
            if (pending_decomps.size() == 0) begin
               $error("result with nothing expected");
               err_count++;
            end else begin
               e = pending_decomps.pop_front();
               check_field("ok", e.ok, rsp_data.ok);
               check_field("translate_x", e.translate_x, rsp_data.translate_x);
               check_field("translate_y", e.translate_y, rsp_data.translate_y);
               check_field("translate_z", e.translate_z, rsp_data.translate_z);
               check_field("rotate_x", e.rotate_x, rsp_data.rotate_x);
               check_field("rotate_y", e.rotate_y, rsp_data.rotate_y);
               check_field("rotate_z", e.rotate_z, rsp_data.rotate_z);
               check_field("scale_x", e.scale_x, rsp_data.scale_x);
               check_field("scale_y", e.scale_y, rsp_data.scale_y);
               check_field("scale_z", e.scale_z, rsp_data.scale_z);
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // sequence of tests
   // ---------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_data   = 16'd0;
      valid_up   = 1'b0;
      burst_left = 0;
      err_count  = 0;
      items_sent = 0;
      zero_thresh  = 1;
      foreach (col_store[i]) col_store[i] = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_shapes();
      test_failure_cases();
      test_gimbal_lock();
      test_extremes();
      test_threshold_edges();

      // random phases under several thresholds, extremes included
      set_threshold(16'd1);
      test_random_matrices(100);
      set_threshold(16'hFFFF);
      test_random_matrices(100);
      set_threshold(16'd0);
      test_random_matrices(100);
      set_threshold(16'($urandom()));
      test_random_matrices(100);

      drain_results();
      if (err_count == 0) begin
         $display("affine_matrix_decompose_tb: clean");
      end else begin
         $display("affine_matrix_decompose_tb: errors");
      end
      $finish;
   end

   // watchdog: far beyond the slowest correct run
   initial begin
      #40000000;
      $display("affine_matrix_decompose_tb: errors");
      $finish;
   end

endmodule
`default_nettype wire

[affine_matrix_decompose.f]
rtl/amd_pkg.sv
rtl/amd_mac.sv
rtl/amd_divsqrt.sv
rtl/amd_cordic.sv
rtl/amd_core.sv
rtl/affine_matrix_decompose.sv
tb/affine_matrix_decompose_tb.sv
